### rtl/core/brtb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package brtb_pkg;

    // Divider geometry: the dividend covers the widest end address (33 bits).
    localparam int DIV_DW  = 33;
    localparam int DIV_BPS = 4;
    localparam int DIV_NST = (DIV_DW + DIV_BPS - 1) / DIV_BPS;
    localparam int DIV_PW  = DIV_NST * DIV_BPS;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Configuration register indexes.
    localparam int         REG_IDX_W       = 1;
    localparam logic [0:0] REG_BLOCK_SIZE  = 1'b0;
    localparam logic [0:0] REG_DISK_BLOCKS = 1'b1;

    // Quotients and remainders of the two dividends.
    typedef struct packed {
        logic [DIV_DW-1:0] qa;
        logic [15:0]       ra;
        logic [DIV_DW-1:0] qb;
        logic [15:0]       rb;
    } t_div_res;

endpackage

`default_nettype wire

### rtl/core/brtb_div.sv
`timescale 1ns / 1ps
`default_nettype none

module brtb_div #(
    parameter int SW = 1
) (
    input  wire logic                      i_clk,
    input  wire logic [brtb_pkg::DIV_NST-1:0] i_en,
    input  wire logic [brtb_pkg::DIV_DW-1:0]  i_a,
    input  wire logic [brtb_pkg::DIV_DW-1:0]  i_b,
    input  wire logic [15:0]               i_d,
    input  wire logic [SW-1:0]             i_side,
    output brtb_pkg::t_div_res             o_res,
    output logic [SW-1:0]                  o_side
);
    import brtb_pkg::*;

    logic [15:0]       r_rem_a [DIV_NST];
    logic [DIV_PW-1:0] r_qd_a  [DIV_NST];
    logic [15:0]       r_rem_b [DIV_NST];
    logic [DIV_PW-1:0] r_qd_b  [DIV_NST];
    logic [SW-1:0]     r_side  [DIV_NST];

    logic [15:0]       n_rem_a [DIV_NST];
    logic [DIV_PW-1:0] n_qd_a  [DIV_NST];
    logic [15:0]       n_rem_b [DIV_NST];
    logic [DIV_PW-1:0] n_qd_b  [DIV_NST];

    // DIV_BPS restoring steps: the dividend shifts out at the top while the
    // quotient bits shift in at the bottom of the same word.
    function automatic logic [16+DIV_PW-1:0] div_steps(
        input logic [15:0]       rem,
        input logic [DIV_PW-1:0] qd,
        input logic [15:0]       d
    );
        logic [16:0]       t;
        logic [15:0]       r;
        logic [DIV_PW-1:0] q;
        r = rem;
        q = qd;
        for (int s = 0; s < DIV_BPS; s++) begin
            t = {r, q[DIV_PW-1]};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
                q = {q[DIV_PW-2:0], 1'b1};
            end else begin
                q = {q[DIV_PW-2:0], 1'b0};
            end
            r = t[15:0];
        end
        return {r, q};
    endfunction

    // Next value of every stage from the stage before it; stage 0 starts from the inputs.
    always_comb begin
        {n_rem_a[0], n_qd_a[0]} = div_steps(16'd0, DIV_PW'(i_a), i_d);
        {n_rem_b[0], n_qd_b[0]} = div_steps(16'd0, DIV_PW'(i_b), i_d);
        for (int k = 1; k < DIV_NST; k++) begin
            {n_rem_a[k], n_qd_a[k]} = div_steps(r_rem_a[k-1], r_qd_a[k-1], i_d);
            {n_rem_b[k], n_qd_b[k]} = div_steps(r_rem_b[k-1], r_qd_b[k-1], i_d);
        end
    end

    // Stage registers; each stage loads when its enable says the beat moves.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_NST; k++) begin
            if (i_en[k]) begin
                r_rem_a[k] <= n_rem_a[k];
                r_qd_a[k]  <= n_qd_a[k];
                r_rem_b[k] <= n_rem_b[k];
                r_qd_b[k]  <= n_qd_b[k];
                r_side[k]  <= (k == 0) ? i_side : r_side[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign o_res.qa = r_qd_a[DIV_NST-1][DIV_DW-1:0];
    assign o_res.ra = r_rem_a[DIV_NST-1];
    assign o_res.qb = r_qd_b[DIV_NST-1][DIV_DW-1:0];
    assign o_res.rb = r_rem_b[DIV_NST-1];
    assign o_side   = r_side[DIV_NST-1];

endmodule

`default_nettype wire

### rtl/core/byte_range_to_block_reads_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Payload
// ---------+-----------+--------------------------------------------------------
// s_axis   | in        | tdata: byte_offset, byte_length
// m_axis   | out       | tdata: status, start_block, block_count, skip_bytes,
//          |           |        copy_bytes; tlast: last
// cfg      | in        | index: 0 block_size, 1 disk_blocks; data: value
//
// A request passes 14 register stages (3 front stages, 9 divider stages, command
// build, beat stage) before its first beat appears.
// Each request gives 1 to 3 beats, one per cycle while m_axis is ready, and new
// requests enter behind earlier ones; the single result channel bounds the rate.
// Every stage holds its beat under backpressure and empty stages close up.
// Synchronous reset clears valid bits and disk_blocks and sets block_size to 512.

module byte_range_to_block_reads_top #(
    parameter int ADDR_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata fields from bit 0: byte_offset[31:0], byte_length[63:32]
    input  wire logic [63:0]                   i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // tdata fields from bit 0: status[1:0], start_block[33:2], block_count[65:34],
    // skip_bytes[81:66], copy_bytes[113:82], zero fill[119:114]
    output logic [119:0]                       o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [brtb_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);
    import brtb_pkg::*;

    localparam int          MW     = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam logic [47:0] AMAX48 = (ADDR_BITS >= 48) ? {48{1'b1}}
                                     : ((48'd1 << ADDR_BITS) - 48'd1);
    localparam int          SIDE_W = 35;

    // Configuration registers.
    logic [15:0] r_block_size;
    logic [31:0] r_disk_blocks;

    // Stage A: masked inputs.
    logic          r_a_v;
    logic [MW-1:0] r_a_off;
    logic [MW-1:0] r_a_len;
    // Stage B: end address and disk size product.
    logic          r_b_v;
    logic [31:0]   r_b_off;
    logic [31:0]   r_b_len;
    logic [32:0]   r_b_end;
    logic          r_b_zero;
    logic [47:0]   r_b_prod;
    // Stage C: status.
    logic          r_c_v;
    logic [31:0]   r_c_off;
    logic [31:0]   r_c_len;
    logic [32:0]   r_c_end;
    logic          r_c_single;
    logic [1:0]    r_c_stat;
    // Divider stages.
    logic [DIV_NST-1:0] r_d_v;
    // Stage E: command fields.
    logic          r_e_v;
    logic          r_e_single;
    logic [1:0]    r_e_stat;
    logic [2:0]    r_e_mask;
    logic [31:0]   r_e_blk;
    logic [15:0]   r_e_mod;
    logic [15:0]   r_e_head;
    logic [31:0]   r_e_rblk;
    logic [31:0]   r_e_run;
    logic [31:0]   r_e_eblk;
    logic [15:0]   r_e_emod;
    // Stage F: beat stage, one bit of the mask for each command still to send.
    logic          r_f_v;
    logic          r_f_single;
    logic [1:0]    r_f_stat;
    logic [2:0]    r_f_mask;
    logic [31:0]   r_f_blk;
    logic [15:0]   r_f_mod;
    logic [15:0]   r_f_head;
    logic [31:0]   r_f_rblk;
    logic [31:0]   r_f_run;
    logic [31:0]   r_f_rcopy;
    logic [31:0]   r_f_eblk;
    logic [31:0]   r_f_tcopy;

    logic               w_beat;
    logic               w_last;
    logic [2:0]         w_sel;
    logic               w_en_a;
    logic               w_en_b;
    logic               w_en_c;
    logic [DIV_NST-1:0] w_en_d;
    logic               w_en_e;
    logic               w_en_f;
    logic               w_ovf;
    logic               w_beyond;
    logic [1:0]         n_c_stat;
    t_div_res           w_res;
    logic [SIDE_W-1:0]  w_side;
    logic               w_d_single;
    logic [1:0]         w_d_stat;
    logic [31:0]        w_d_len;
    logic               w_hv;
    logic [15:0]        w_room;
    logic               w_head_only;
    logic [32:0]        w_rblk;
    logic               w_tfull;
    logic [32:0]        w_run;
    logic [2:0]         n_e_mask;
    logic [47:0]        w_rprod;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= 16'd512;
            r_disk_blocks <= 32'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BLOCK_SIZE:  r_block_size  <= i_cfg_data[15:0];
                REG_DISK_BLOCKS: r_disk_blocks <= i_cfg_data;
            endcase
        end
    end

    // Output beat selection: the lowest pending command goes first.
    assign w_sel[0] = r_f_mask[0];
    assign w_sel[1] = r_f_mask[1] & ~r_f_mask[0];
    assign w_sel[2] = r_f_mask[2] & ~r_f_mask[1] & ~r_f_mask[0];
    assign w_last   = (r_f_mask & ~w_sel) == 3'b000;
    assign w_beat   = o_m_axis_tvalid && i_m_axis_tready;

    // Stage enables: a stage moves when it is empty or the next one moves.
    always_comb begin
        logic nxt;
        w_en_f = !r_f_v || (w_beat && w_last);
        w_en_e = !r_e_v || w_en_f;
        nxt    = w_en_e;
        for (int k = DIV_NST - 1; k >= 0; k--) begin
            w_en_d[k] = !r_d_v[k] || nxt;
            nxt       = w_en_d[k];
        end
        w_en_c = !r_c_v || w_en_d[0];
        w_en_b = !r_b_v || w_en_c;
        w_en_a = !r_a_v || w_en_b;
    end

    assign o_s_axis_tready = w_en_a;

    // Valid bits and the pending command mask.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v    <= 1'b0;
            r_b_v    <= 1'b0;
            r_c_v    <= 1'b0;
            r_d_v    <= '0;
            r_e_v    <= 1'b0;
            r_f_v    <= 1'b0;
            r_f_mask <= 3'b000;
        end else begin
            if (w_en_a) r_a_v <= i_s_axis_tvalid;
            if (w_en_b) r_b_v <= r_a_v;
            if (w_en_c) r_c_v <= r_b_v;
            if (w_en_d[0]) r_d_v[0] <= r_c_v;
            for (int k = 1; k < DIV_NST; k++) begin
                if (w_en_d[k]) r_d_v[k] <= r_d_v[k-1];
            end
            if (w_en_e) r_e_v <= r_d_v[DIV_NST-1];
            if (w_en_f) begin
                r_f_v    <= r_e_v;
                r_f_mask <= r_e_v ? r_e_mask : 3'b000;
            end else if (w_beat) begin
                r_f_mask <= r_f_mask & ~w_sel;
            end
        end
    end

    // Front stages: input capture, end address, status.
    assign w_ovf    = {15'd0, r_b_end} > AMAX48;
    assign w_beyond = ({15'd0, r_b_end} >= r_b_prod) || ({15'd0, r_b_end} >= AMAX48);

    always_comb begin
        if (r_b_zero) begin
            n_c_stat = ST_OK;
        end else if (w_ovf) begin
            n_c_stat = ST_OVF;
        end else if (w_beyond) begin
            n_c_stat = ST_RANGE;
        end else begin
            n_c_stat = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_off <= i_s_axis_tdata[MW-1:0];
            r_a_len <= i_s_axis_tdata[32+MW-1:32];
        end
        if (w_en_b) begin
            r_b_off  <= 32'(r_a_off);
            r_b_len  <= 32'(r_a_len);
            r_b_end  <= 33'(r_a_off) + 33'(r_a_len) - 33'd1;
            r_b_zero <= r_a_len == '0;
            r_b_prod <= {16'd0, r_disk_blocks} * {32'd0, r_block_size};
        end
        if (w_en_c) begin
            r_c_off    <= r_b_off;
            r_c_len    <= r_b_len;
            r_c_end    <= r_b_end;
            r_c_stat   <= n_c_stat;
            r_c_single <= r_b_zero || (n_c_stat != ST_OK);
        end
    end

    // Start and end addresses divided by the block size.
    brtb_div #(
        .SW(SIDE_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (w_en_d),
        .i_a    (33'(r_c_off)),
        .i_b    (r_c_end),
        .i_d    (r_block_size),
        .i_side ({r_c_single, r_c_stat, r_c_len}),
        .o_res  (w_res),
        .o_side (w_side)
    );

    assign {w_d_single, w_d_stat, w_d_len} = w_side;

    // Head, run and tail from the start and end block positions.
    assign w_hv        = w_res.ra != 16'd0;
    assign w_room      = r_block_size - w_res.ra;
    assign w_head_only = w_hv && (w_d_len <= {16'd0, w_room});
    assign w_rblk      = {1'b0, w_res.qa[31:0]} + 33'(w_hv);
    assign w_tfull     = w_res.rb == (r_block_size - 16'd1);
    assign w_run       = w_res.qb - w_rblk + 33'(w_tfull);

    always_comb begin
        if (w_d_single) begin
            n_e_mask = 3'b001;
        end else begin
            n_e_mask = {!w_head_only && !w_tfull, !w_head_only && (w_run != 33'd0), w_hv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_e) begin
            r_e_single <= w_d_single;
            r_e_stat   <= w_d_stat;
            r_e_mask   <= n_e_mask;
            r_e_blk    <= w_res.qa[31:0];
            r_e_mod    <= w_res.ra;
            r_e_head   <= w_head_only ? w_d_len[15:0] : w_room;
            r_e_rblk   <= w_rblk[31:0];
            r_e_run    <= w_run[31:0];
            r_e_eblk   <= w_res.qb[31:0];
            r_e_emod   <= w_res.rb;
        end
    end

    // Byte count of the whole-block run, registered into the beat stage.
    assign w_rprod = {16'd0, r_e_run} * {32'd0, r_block_size};

    always_ff @(posedge i_clk) begin
        if (w_en_f) begin
            r_f_single <= r_e_single;
            r_f_stat   <= r_e_stat;
            r_f_blk    <= r_e_blk;
            r_f_mod    <= r_e_mod;
            r_f_head   <= r_e_head;
            r_f_rblk   <= r_e_rblk;
            r_f_run    <= r_e_run;
            r_f_rcopy  <= w_rprod[31:0];
            r_f_eblk   <= r_e_eblk;
            r_f_tcopy  <= 32'({1'b0, r_e_emod} + 17'd1);
        end
    end

    // Output beat from the selected command.
    assign o_m_axis_tvalid = r_f_v;
    assign o_m_axis_tlast  = w_last;

    always_comb begin
        o_m_axis_tdata        = '0;
        o_m_axis_tdata[1:0]   = r_f_stat;
        if (!r_f_single) begin
            case (w_sel)
                3'b001: begin
                    o_m_axis_tdata[33:2]   = r_f_blk;
                    o_m_axis_tdata[65:34]  = 32'd1;
                    o_m_axis_tdata[81:66]  = r_f_mod;
                    o_m_axis_tdata[113:82] = {16'd0, r_f_head};
                end
                3'b010: begin
                    o_m_axis_tdata[33:2]   = r_f_rblk;
                    o_m_axis_tdata[65:34]  = r_f_run;
                    o_m_axis_tdata[113:82] = r_f_rcopy;
                end
                default: begin
                    o_m_axis_tdata[33:2]   = r_f_eblk;
                    o_m_axis_tdata[65:34]  = 32'd1;
                    o_m_axis_tdata[113:82] = r_f_tcopy;
                end
            endcase
        end
    end

    // A beat on the output always has a command pending behind it.
    a_valid_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_f_mask != 3'b000))
        else $error("output valid with no pending command");

    // A request that is not finished keeps the output valid.
    a_more_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && !w_last) |=> o_m_axis_tvalid)
        else $error("request dropped before its last beat");

    // Error and empty results are a single beat.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_v && r_f_single) |-> (o_m_axis_tlast && (o_m_axis_tdata[65:34] == 32'd0)))
        else $error("single result is not a lone empty beat");

    // A nonzero status only comes as a lone beat.
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[1:0] != ST_OK)) |-> r_f_single)
        else $error("error status on a command beat");

    // An accepted request reaches the first stage.
    a_input_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_a_v)
        else $error("accepted request lost at the first stage");

endmodule

`default_nettype wire
